[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, sampled on clk, off while rst is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, always active
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// widths, scaling constants and sector codes for the hsv to rgb pixel unit
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

   localparam int HUE_W = 16;
   localparam int PCT_W = 8;
   localparam int PIX_W = 8;

   // hue reduction: q = (hue * HUE_RECIP) >> HUE_SHIFT is exact hue / 360
   localparam int HUE_MOD   = 360;
   localparam int HUE_RECIP = 46604;
   localparam int HUE_SHIFT = 24;

   localparam int PCT_MAX = 100;

   // top = ((v*51) >> 2) / 5
   localparam int TOP_RECIP = 1639;
   localparam int TOP_SHIFT = 13;
   // bottom = ((v*(100-s)*51) >> 4) / 125
   localparam int BOT_RECIP = 33555;
   localparam int BOT_SHIFT = 22;
   // mid = ((n*17) >> 6) / 625
   localparam int MID_RECIP = 214749;
   localparam int MID_SHIFT = 27;

   typedef enum logic [2:0] {
      SEC_0 = 3'd0,
      SEC_1 = 3'd1,
      SEC_2 = 3'd2,
      SEC_3 = 3'd3,
      SEC_4 = 3'd4,
      SEC_5 = 3'd5
   } sector_type;

endpackage

`default_nettype wire

[design/hsv_to_rgb_pixel_unit.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// pipelined conversion of one hsv pixel to an 8-bit rgb triple
// ----------------------------------------------------------------------------
// usage
//   input beat: req_hue, req_saturation, req_brightness are taken at a rising
//   edge with start high and busy low. busy is only high during reset, so a
//   new pixel can be taken at every clock edge.
//   result beat: rsp_red, rsp_green, rsp_blue are shown for one cycle with
//   rsp_valid high. the receiver cannot hold results off and none is needed,
//   since nothing inside ever stalls.
// pipeline and throughput
//   five register stages; a pixel accepted at a rising edge is on the result
//   ports once it has passed all five. one pixel per clock sustained, since
//   nothing stalls and each of the five stages holds one item.
// reset
//   synchronous, active high: all stage valid bits are cleared, so pixels in
//   flight are dropped and no result beat follows. payload is not reset.
// arithmetic
//   hue mod 360, and the divides by 100, 10000 and 600000, are done as
//   multiplies by exact reciprocals followed by shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [hsvrgb_pkg::HUE_W-1:0]     req_hue,
   input  wire logic [hsvrgb_pkg::PCT_W-1:0]     req_saturation,
   input  wire logic [hsvrgb_pkg::PCT_W-1:0]     req_brightness,
   output logic                                  rsp_valid,
   output logic [hsvrgb_pkg::PIX_W-1:0]          rsp_red,
   output logic [hsvrgb_pkg::PIX_W-1:0]          rsp_green,
   output logic [hsvrgb_pkg::PIX_W-1:0]          rsp_blue
);

   // ---------------------------------------------------------------- control
   logic       accept;
   logic [4:0] vld_ff;
   logic [4:0] vld_in;

   // no stall inside: only reset blocks intake
   assign busy   = reset;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[3:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // clamp percentages, quotient of hue / 360
   logic [31:0] hue_prod;
   logic [7:0]  q1_in;
   logic [6:0]  s1_in;
   logic [6:0]  v1_in;
   logic [15:0] hue1_ff;
   logic [7:0]  q1_ff;
   logic [6:0]  s1_ff;
   logic [6:0]  v1_ff;

   always_comb begin
      hue_prod = 32'(req_hue) * 32'(hsvrgb_pkg::HUE_RECIP);
      q1_in    = hue_prod[hsvrgb_pkg::HUE_SHIFT +: 8];
      s1_in    = (req_saturation > 8'(hsvrgb_pkg::PCT_MAX)) ?
                 7'(hsvrgb_pkg::PCT_MAX) : req_saturation[6:0];
      v1_in    = (req_brightness > 8'(hsvrgb_pkg::PCT_MAX)) ?
                 7'(hsvrgb_pkg::PCT_MAX) : req_brightness[6:0];
   end

   always_ff @(posedge clock) begin
      hue1_ff <= req_hue;
      q1_ff   <= q1_in;
      s1_ff   <= s1_in;
      v1_ff   <= v1_in;
   end

   // ---------------------------------------------------------------- stage 2
   // remainder h, s*v and v*(100-s)
   logic [16:0] qx360;
   logic [16:0] hrem;
   logic [8:0]  h2_in;
   logic [13:0] sv2_in;
   logic [13:0] vns2_in;
   logic [8:0]  h2_ff;
   logic [13:0] sv2_ff;
   logic [13:0] vns2_ff;
   logic [6:0]  v2_ff;

   always_comb begin
      qx360   = 17'(q1_ff) * 17'(hsvrgb_pkg::HUE_MOD);
      hrem    = 17'(hue1_ff) - qx360;
      h2_in   = hrem[8:0];
      sv2_in  = 14'(s1_ff) * 14'(v1_ff);
      vns2_in = 14'(v1_ff) * 14'(7'(hsvrgb_pkg::PCT_MAX) - s1_ff);
   end

   always_ff @(posedge clock) begin
      h2_ff   <= h2_in;
      sv2_ff  <= sv2_in;
      vns2_ff <= vns2_in;
      v2_ff   <= v1_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // sector, ramp d, mid numerator and pre-scaled top and bottom
   hsvrgb_pkg::sector_type sec3_in;
   hsvrgb_pkg::sector_type sec3_ff;
   logic [8:0]  base;
   logic [8:0]  r120_w;
   logic [6:0]  r120;
   logic [5:0]  ramp_dist;
   logic [5:0]  ramp;
   logic [19:0] n3_in;
   logic [12:0] v51;
   logic [18:0] vns51;
   logic [10:0] wt3_in;
   logic [14:0] zb3_in;
   logic [19:0] n3_ff;
   logic [10:0] wt3_ff;
   logic [14:0] zb3_ff;

   always_comb begin
      priority if (h2_ff >= 9'd300) begin
         sec3_in = hsvrgb_pkg::SEC_5;
         base    = 9'd240;
      end else if (h2_ff >= 9'd240) begin
         sec3_in = hsvrgb_pkg::SEC_4;
         base    = 9'd240;
      end else if (h2_ff >= 9'd180) begin
         sec3_in = hsvrgb_pkg::SEC_3;
         base    = 9'd120;
      end else if (h2_ff >= 9'd120) begin
         sec3_in = hsvrgb_pkg::SEC_2;
         base    = 9'd120;
      end else if (h2_ff >= 9'd60) begin
         sec3_in = hsvrgb_pkg::SEC_1;
         base    = 9'd0;
      end else begin
         sec3_in = hsvrgb_pkg::SEC_0;
         base    = 9'd0;
      end
      r120_w    = h2_ff - base;
      r120      = r120_w[6:0];
      ramp_dist = (r120 >= 7'd60) ? 6'(r120 - 7'd60) : 6'(7'd60 - r120);
      ramp      = 6'd60 - ramp_dist;
      n3_in     = 20'(sv2_ff) * 20'(ramp) + 20'(vns2_ff) * 20'd60;
      v51       = 13'(v2_ff) * 13'd51;
      vns51     = 19'(vns2_ff) * 19'd51;
      wt3_in    = v51[12:2];
      zb3_in    = vns51[18:4];
   end

   always_ff @(posedge clock) begin
      sec3_ff <= sec3_in;
      n3_ff   <= n3_in;
      wt3_ff  <= wt3_in;
      zb3_ff  <= zb3_in;
   end

   // ---------------------------------------------------------------- stage 4
   // top and bottom finished, mid pre-scaled by 17/64
   logic [23:0] n17;
   logic [21:0] top_prod;
   logic [30:0] bot_prod;
   logic [17:0] zm4_in;
   logic [17:0] zm4_ff;
   logic [7:0]  top4_ff;
   logic [7:0]  bot4_ff;
   hsvrgb_pkg::sector_type sec4_ff;

   always_comb begin
      n17      = {n3_ff, 4'd0} + 24'(n3_ff);
      zm4_in   = n17[23:6];
      top_prod = 22'(wt3_ff) * 22'(hsvrgb_pkg::TOP_RECIP);
      bot_prod = 31'(zb3_ff) * 31'(hsvrgb_pkg::BOT_RECIP);
   end

   always_ff @(posedge clock) begin
      zm4_ff  <= zm4_in;
      top4_ff <= top_prod[hsvrgb_pkg::TOP_SHIFT +: 8];
      bot4_ff <= bot_prod[hsvrgb_pkg::BOT_SHIFT +: 8];
      sec4_ff <= sec3_ff;
   end

   // ---------------------------------------------------------------- stage 5
   // mid finished, route levels to channels by sector
   logic [35:0] mid_prod;
   logic [7:0]  mid;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;
   logic [7:0]  red_ff;
   logic [7:0]  green_ff;
   logic [7:0]  blue_ff;

   always_comb begin
      mid_prod = 36'(zm4_ff) * 36'(hsvrgb_pkg::MID_RECIP);
      mid      = mid_prod[hsvrgb_pkg::MID_SHIFT +: 8];
      unique case (sec4_ff)
         hsvrgb_pkg::SEC_0: begin
            red_in = top4_ff; green_in = mid;     blue_in = bot4_ff;
         end
         hsvrgb_pkg::SEC_1: begin
            red_in = mid;     green_in = top4_ff; blue_in = bot4_ff;
         end
         hsvrgb_pkg::SEC_2: begin
            red_in = bot4_ff; green_in = top4_ff; blue_in = mid;
         end
         hsvrgb_pkg::SEC_3: begin
            red_in = bot4_ff; green_in = mid;     blue_in = top4_ff;
         end
         hsvrgb_pkg::SEC_4: begin
            red_in = mid;     green_in = bot4_ff; blue_in = top4_ff;
         end
         default: begin
            red_in = top4_ff; green_in = bot4_ff; blue_in = mid;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = vld_ff[4];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

[design/hsvrgb_checker.sv]
// ----------------------------------------------------------------------------
// hsvrgb_checker
// port-level assertions for the hsv to rgb pixel unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsvrgb_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic [hsvrgb_pkg::PCT_W-1:0] req_saturation,
   input wire logic [hsvrgb_pkg::PCT_W-1:0] req_brightness,
   input wire logic                         rsp_valid,
   input wire logic [hsvrgb_pkg::PIX_W-1:0] rsp_red,
   input wire logic [hsvrgb_pkg::PIX_W-1:0] rsp_green,
   input wire logic [hsvrgb_pkg::PIX_W-1:0] rsp_blue
);

   // reset flushes the pipeline
   `ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

   // every accepted beat is seen on the result port once it has passed the pipeline
   `ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##5 rsp_valid)

   // no result beat without an accepted beat that entered the pipeline before it
   `ASSERT_IMPLY(a_no_phantom, clock, reset, rsp_valid, $past(start && !busy, 5))

   // zero brightness gives black
   `ASSERT_IMPLY(a_black, clock, reset, start && !busy && req_brightness == '0,
      ##5 (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))

   // zero saturation gives gray
   `ASSERT_IMPLY(a_gray, clock, reset, start && !busy && req_saturation == '0,
      ##5 (rsp_red == rsp_green && rsp_green == rsp_blue))

endmodule

bind hsv_to_rgb_pixel_unit hsvrgb_checker u_hsvrgb_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_saturation (req_saturation),
   .req_brightness (req_brightness),
   .rsp_valid      (rsp_valid),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue)
);

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb - hsv to rgb pixel unit testbench
// drives pixels into the command port, predicts each rgb triple with an
// independent integer model and checks every result beat in order. covers
// hue wrap, saturation and brightness clamping, all six hue sectors and
// random pixels under several sender idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsvrgb_pkg::*;

   // one expected rgb triple
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_pixel_t;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [HUE_W-1:0]    req_hue;
   logic [PCT_W-1:0]    req_saturation;
   logic [PCT_W-1:0]    req_brightness;
   logic                rsp_valid;
   logic [PIX_W-1:0]    rsp_red;
   logic [PIX_W-1:0]    rsp_green;
   logic [PIX_W-1:0]    rsp_blue;

   // pixels accepted but not yet seen on the result port, oldest first
   rgb_pixel_t  pending_pixels[$];
   int unsigned pixels_sent;
   int unsigned pixels_checked;
   int unsigned mismatches;
   // chance in percent that the sender holds off before a beat
   int unsigned sender_idle_pct;

   hsv_to_rgb_pixel_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #500us;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction: exact integer conversion, no state
   // ------------------------------------------------------------------------
   function automatic rgb_pixel_t predict_rgb(input logic [HUE_W-1:0] hue,
                                              input logic [PCT_W-1:0] sat_in,
                                              input logic [PCT_W-1:0] bri_in);
      int unsigned h, s, v;
      int unsigned top_lvl, bot_lvl, mid_lvl;
      int unsigned r120, hue_dist, ramp;
      sector_type  sec;
      rgb_pixel_t  px;
      h = int'(hue) % HUE_MOD;
      // percentages saturate at 100
      s = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
      v = (bri_in > PCT_MAX) ? PCT_MAX : bri_in;
      top_lvl = (v * 255) / 100;
      bot_lvl = (v * (100 - s) * 255) / 10000;
      // triangle ramp: 0 at sector edges divisible by 120, 60 at odd edges
      r120     = h % 120;
      hue_dist = (r120 >= 60) ? (r120 - 60) : (60 - r120);
      ramp     = 60 - hue_dist;
      mid_lvl  = ((s * v * ramp + 60 * v * (100 - s)) * 255) / 600000;
      sec = sector_type'(h / 60);
      case (sec)
         SEC_0: px = '{PIX_W'(top_lvl), PIX_W'(mid_lvl), PIX_W'(bot_lvl)};
         SEC_1: px = '{PIX_W'(mid_lvl), PIX_W'(top_lvl), PIX_W'(bot_lvl)};
         SEC_2: px = '{PIX_W'(bot_lvl), PIX_W'(top_lvl), PIX_W'(mid_lvl)};
         SEC_3: px = '{PIX_W'(bot_lvl), PIX_W'(mid_lvl), PIX_W'(top_lvl)};
         SEC_4: px = '{PIX_W'(mid_lvl), PIX_W'(bot_lvl), PIX_W'(top_lvl)};
         default: px = '{PIX_W'(top_lvl), PIX_W'(bot_lvl), PIX_W'(mid_lvl)};
      endcase
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // result checker: every result beat against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rgb_pixel_t want;
      bit         bad;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            // a beat nobody asked for
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat r=%0d g=%0d b=%0d",
                        $realtime, rsp_red, rsp_green, rsp_blue);
         end else begin
            want = pending_pixels.pop_front();
            bad  = 1'b0;
            if (rsp_red !== want.red)     bad = 1'b1;
            if (rsp_green !== want.green) bad = 1'b1;
            if (rsp_blue !== want.blue)   bad = 1'b1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: pixel %0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                           $realtime, pixels_checked, want.red, want.green,
                           want.blue, rsp_red, rsp_green, rsp_blue);
            end
            pixels_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // send one pixel beat; start stays high into the next call unless the
   // sender decides to idle, so back-to-back beats need no toggling
   // ------------------------------------------------------------------------
   task automatic send_pixel(input logic [HUE_W-1:0] hue,
                             input logic [PCT_W-1:0] sat_in,
                             input logic [PCT_W-1:0] bri_in);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat_in;
      req_brightness <= bri_in;
      // beat is taken at the first edge with busy low
      do @(posedge clock); while (busy);
      pending_pixels.push_back(predict_rgb(hue, sat_in, bri_in));
      pixels_sent++;
   endtask

   // corner values: zero, full scale, clamp thresholds, hue wrap
   task automatic test_clamp_and_wrap();
      send_pixel(16'd0,     8'd0,   8'd0);
      send_pixel(16'd65535, 8'd255, 8'd255);
      send_pixel(16'd359,   8'd100, 8'd100);
      send_pixel(16'd360,   8'd101, 8'd101);
      send_pixel(16'd720,   8'd50,  8'd255);
      send_pixel(16'd65535, 8'd0,   8'd100);
      send_pixel(16'd1,     8'd255, 8'd0);
      send_pixel(16'd43690, 8'd170, 8'd85);
   endtask

   // hues at sector edges and middles, at least one in each of the six 60 degree sectors
   task automatic test_sectors();
      int unsigned hues[12] = '{0, 30, 59, 60, 90, 119, 120, 180, 240, 270, 300, 359};
      foreach (hues[i]) begin
         if (i % 2 == 0)
            send_pixel(HUE_W'(hues[i]), 8'd100, 8'd100);
         else
            send_pixel(HUE_W'(hues[i]), 8'd37, 8'd83);
      end
   endtask

   // random pixels: mostly in-range percentages, the rest across the full byte
   task automatic test_random_pixels(input int unsigned count);
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] sat_in, bri_in;
      repeat (count) begin
         hue    = ($urandom_range(3, 0) == 0) ? HUE_W'($urandom_range(359, 0))
                                              : HUE_W'($urandom_range(65535, 0));
         sat_in = ($urandom_range(9, 0) < 6) ? PCT_W'($urandom_range(100, 0))
                                             : PCT_W'($urandom_range(255, 0));
         bri_in = ($urandom_range(9, 0) < 6) ? PCT_W'($urandom_range(100, 0))
                                             : PCT_W'($urandom_range(255, 0));
         send_pixel(hue, sat_in, bri_in);
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int unsigned drain_cycles;
      reset           = 1'b1;
      start           = 1'b0;
      req_hue         = '0;
      req_saturation  = '0;
      req_brightness  = '0;
      pixels_sent     = 0;
      pixels_checked  = 0;
      mismatches      = 0;
      sender_idle_pct = 23;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part with a light idle mix
      test_clamp_and_wrap();
      test_sectors();
      test_random_pixels(540);
      // heavy sender idling
      sender_idle_pct = 72;
      test_random_pixels(530);
      // full rate, one beat every clock
      sender_idle_pct = 0;
      test_random_pixels(530);
      start <= 1'b0;

      // drain the pipeline, then keep watching for stray beats
      drain_cycles = 0;
      while (pending_pixels.size() != 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);

      if (pending_pixels.size() != 0) begin
         mismatches += pending_pixels.size();
         $display("%0d expected pixels never arrived", pending_pixels.size());
      end

      $display("sent %0d pixels, checked %0d: hue wrap, percent clamps, six sectors",
               pixels_sent, pixels_checked);
      $display("idle mixes 23, 72 and 0 percent on the sender, %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
